>>> hw/rtl/assert_macros.svh
// Shared assertion macros; clk and arst_n must be visible at the use site.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> hw/rtl/brti_pkg.sv
`default_nettype none
package brti_pkg;

	localparam int unsigned MaxLevelsDefault = 16;
	localparam logic [15:0] BucketCountReset = 16'hFFFF;

	typedef enum logic [2:0] {
		OP_PATH   = 3'd0,
		OP_PARENT = 3'd1,
		OP_LEFT   = 3'd2,
		OP_RIGHT  = 3'd3,
		OP_P2N    = 3'd4,
		OP_N2P    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_EMIT,
		ST_PATH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
		logic last;
	} dp_cmd_t;

	typedef struct packed {
		logic [15:0] idx;
		logic [4:0]  lvl;
	} swap_res_t;

	// position of the leading one, 0 when none
	function automatic logic [4:0] msb_pos(input logic [16:0] t);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 17; i++) begin
			if (t[i]) begin
				p = 5'(i);
			end
		end
		return p;
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] x);
		logic [15:0] y;
		for (int i = 0; i < 16; i++) begin
			y[i] = x[15 - i];
		end
		return y;
	endfunction

	// normal <-> physical order, self-inverse; level is kept
	function automatic swap_res_t swap_order(input logic [15:0] x);
		logic [16:0] t;
		logic [4:0]  l;
		logic [16:0] base;
		logic [15:0] q;
		logic [15:0] r;
		swap_res_t   res;
		t    = {1'b0, x} + 17'd1;
		l    = msb_pos(t);
		base = (17'd1 << l) - 17'd1;
		q    = t[15:0] & base[15:0];
		r    = rev16(q) >> (5'd16 - l);
		res.idx = 16'(base + {1'b0, r});
		res.lvl = l;
		return res;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/brti_datapath.sv
`default_nettype none
module brti_datapath import brti_pkg::*; #(
	parameter int unsigned MAX_LEVELS = MaxLevelsDefault,
	localparam int unsigned LW = $clog2(MAX_LEVELS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [15:0]   bucket_count,
	input  wire logic [2:0]    opcode,
	input  wire logic [15:0]   node_or_leaf,
	input  wire dp_cmd_t       cmd,
	output logic               slot_free,
	output logic [LW-1:0]      leaf_level,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [15:0]        node_index,
	output logic [3:0]         node_level,
	output logic               out_of_tree,
	output logic               last
);

	localparam logic [4:0] Cap = 5'(MAX_LEVELS - 1);
	localparam logic [4:0] ResetEnc = 5'd15;
	localparam logic [LW-1:0] LeafReset = LW'((ResetEnc > Cap) ? Cap : ResetEnc);

	logic [15:0]   bc_q;
	logic [LW-1:0] leaf_q;
	logic [2:0]    op_q;
	logic [15:0]   n_q;
	logic          none_q;
	logic          out_valid_q;
	logic [15:0]   idx_q;
	logic [3:0]    lvl_q;
	logic          oot_q;
	logic          last_q;

	logic [4:0]  cfg_enc;
	logic [16:0] leaf_mask;
	swap_res_t   sw;
	logic [17:0] child;
	logic        drop;

	always_comb begin
		cfg_enc   = msb_pos({1'b0, bucket_count});
		leaf_mask = (17'd1 << leaf_q) - 17'd1;
		sw        = swap_order(n_q);
		child     = {1'b0, sw.idx, 1'b0} + ((op_q == OP_LEFT) ? 18'd1 : 18'd2);
		drop      = none_q || (op_q > OP_N2P) || (sw.idx >= bc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= BucketCountReset;
			leaf_q      <= LeafReset;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				bc_q   <= bucket_count;
				leaf_q <= LW'((cfg_enc > Cap) ? Cap : cfg_enc);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= opcode;
			none_q <= 1'b0;
			if (opcode == OP_PATH) begin
				n_q <= leaf_mask[15:0] + (node_or_leaf & leaf_mask[15:0]);
			end else begin
				n_q <= node_or_leaf;
			end
		end else if (cmd.step) begin
			if (op_q == OP_PARENT) begin
				none_q <= (n_q == 16'd0);
				n_q    <= (sw.idx - 16'd1) >> 1;
			end else begin
				none_q <= (child >= 18'd65535);
				n_q    <= child[15:0];
			end
		end else if (cmd.emit) begin
			n_q <= (n_q - 16'd1) >> 1;
		end
		if (cmd.emit) begin
			idx_q  <= drop ? 16'd0 : sw.idx;
			lvl_q  <= drop ? 4'd0 : sw.lvl[3:0];
			oot_q  <= drop;
			last_q <= cmd.last;
		end
	end

	assign slot_free   = !out_valid_q || out_ready;
	assign leaf_level  = leaf_q;
	assign out_valid   = out_valid_q;
	assign node_index  = idx_q;
	assign node_level  = lvl_q;
	assign out_of_tree = oot_q;
	assign last        = last_q;

`include "assert_macros.svh"
	`ASSERT_NOW(a_emit_into_free_slot, cmd.emit, !out_valid_q || out_ready)
	`ASSERT_NOW(a_oot_zero, out_valid_q && oot_q, idx_q == 16'd0 && lvl_q == 4'd0)

endmodule
`default_nettype wire

>>> hw/rtl/brti_ctrl.sv
`default_nettype none
module brti_ctrl import brti_pkg::*; #(
	parameter int unsigned MAX_LEVELS = MaxLevelsDefault,
	localparam int unsigned LW = $clog2(MAX_LEVELS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [2:0]    opcode,
	input  wire logic          slot_free,
	input  wire logic [LW-1:0] leaf_level,
	output dp_cmd_t            cmd
);

	state_t        state_q, state_d;
	logic [LW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = leaf_level;
					case (opcode) inside
						OP_PATH:                     state_d = ST_PATH;
						OP_PARENT, OP_LEFT, OP_RIGHT: state_d = ST_STEP;
						default:                     state_d = ST_EMIT;
					endcase
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PATH: begin
				if (slot_free) begin
					cmd.emit = 1'b1;
					cmd.last = (cnt_q == '0);
					if (cnt_q == '0) begin
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q - LW'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`include "assert_macros.svh"
	`ASSERT_NEXT(a_last_ends_item, cmd.emit && cmd.last, state_q == ST_IDLE)
	`ASSERT_NEXT(a_path_walks_down, state_q == ST_PATH && cmd.emit && cnt_q != '0, state_q == ST_PATH && cnt_q == $past(cnt_q) - LW'(1))

endmodule
`default_nettype wire

>>> hw/rtl/bit_reversed_tree_index_unit.sv
// Sequence: a conversion or unknown opcode goes from accept to ST_EMIT, parent and child via
// ST_STEP to ST_EMIT; a path gives leaf level + 1 results, one per cycle while the output slot is free.
// Throughput: the next item is accepted the cycle after the last result is registered,
// so no new item enters while a path walks through the shared swap unit.
// Reset: asynchronous, idle with an empty output register and bucket count 65535.
`default_nettype none
module bit_reversed_tree_index_unit import brti_pkg::*; #(
	parameter int unsigned MAX_LEVELS = MaxLevelsDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] bucket_count,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] node_or_leaf,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      node_index,
	output logic [3:0]       node_level,
	output logic             out_of_tree,
	output logic             last
);

	localparam int unsigned LW = $clog2(MAX_LEVELS);

	dp_cmd_t       cmd;
	logic          slot_free;
	logic [LW-1:0] leaf_level;

	assign cfg_ready = 1'b1;

	brti_ctrl #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.slot_free  (slot_free),
		.leaf_level (leaf_level),
		.cmd        (cmd)
	);

	brti_datapath #(
		.MAX_LEVELS(MAX_LEVELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.bucket_count (bucket_count),
		.opcode       (opcode),
		.node_or_leaf (node_or_leaf),
		.cmd          (cmd),
		.slot_free    (slot_free),
		.leaf_level   (leaf_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.node_index   (node_index),
		.node_level   (node_level),
		.out_of_tree  (out_of_tree),
		.last         (last)
	);

endmodule
`default_nettype wire

>>> tb/sv/bit_reversed_tree_index_unit_tb.sv
`timescale 1ns / 100ps
module bit_reversed_tree_index_unit_tb;
	import brti_pkg::*;

	localparam logic [2:0] OP_RSVD_A = 3'd6;
	localparam logic [2:0] OP_RSVD_B = 3'd7;
	localparam int unsigned LeafLevelCap = MaxLevelsDefault - 1;

	typedef enum int unsigned {
		RX_STREAM,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_mode_t;

	typedef struct packed {
		logic [15:0] idx;
		logic [3:0]  lvl;
		logic        oot;
		logic        last;
	} tree_node_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] bucket_count = 16'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = OP_PATH;
	logic [15:0] node_or_leaf = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] node_index;
	logic [3:0]  node_level;
	logic        out_of_tree;
	logic        last;

	tree_node_t  expected_nodes[$];
	int unsigned tree_buckets = 32'(BucketCountReset);
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;
	rx_mode_t    rx_mode = RX_STREAM;
	int unsigned rx_left = 0;
	int unsigned rx_tick = 0;

	bit_reversed_tree_index_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.bucket_count (bucket_count),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.node_or_leaf (node_or_leaf),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.node_index   (node_index),
		.node_level   (node_level),
		.out_of_tree  (out_of_tree),
		.last         (last)
	);

	always #4 clk = ~clk;

	// floor(log2(x + 1))
	function automatic int unsigned node_depth(input int unsigned x);
		int unsigned t;
		int unsigned l;
		t = x + 1;
		l = 0;
		while (t > 1) begin
			t = t >> 1;
			l++;
		end
		return l;
	endfunction

	// normal <-> physical, self-inverse
	function automatic int unsigned swap_positions(input int unsigned x);
		int unsigned l;
		int unsigned start;
		int unsigned pos;
		int unsigned y;
		int unsigned i;
		l = node_depth(x);
		start = (32'd1 << l) - 1;
		pos = x - start;
		y = 0;
		for (i = 0; i < l && i < 31; i++) begin
			y = (y << 1) | (pos & 1);
			pos = pos >> 1;
		end
		return start + y;
	endfunction

	function automatic void add_node(input int unsigned idx, input int unsigned lvl,
			input bit none, input bit fin);
		tree_node_t n;
		if (none || idx >= tree_buckets) begin
			n.idx = 16'd0;
			n.lvl = 4'd0;
			n.oot = 1'b1;
		end else begin
			n.idx = idx[15:0];
			n.lvl = lvl[3:0];
			n.oot = 1'b0;
		end
		n.last = fin;
		expected_nodes.insert(expected_nodes.size(), n);
	endfunction

	function automatic void predict_nodes(input logic [2:0] op, input logic [15:0] v);
		int unsigned n;
		int unsigned r;
		int unsigned lvl;
		int unsigned t;
		bit done;
		case (op)
			OP_PATH: begin
				lvl = 0;
				t = tree_buckets;
				while (t > 1) begin
					t = t >> 1;
					lvl++;
				end
				if (lvl > LeafLevelCap) begin
					lvl = LeafLevelCap;
				end
				n = ((32'd1 << lvl) - 1) + (v & ((32'd1 << lvl) - 1));
				done = 1'b0;
				while (!done) begin
					add_node(swap_positions(n), lvl, 1'b0, lvl == 0);
					if (lvl == 0) begin
						done = 1'b1;
					end else begin
						n = (n - 1) >> 1;
						lvl--;
					end
				end
			end
			OP_PARENT: begin
				if (v == 16'd0) begin
					add_node(0, 0, 1'b1, 1'b1);
				end else begin
					n = (swap_positions(v) - 1) >> 1;
					r = swap_positions(n);
					add_node(r, node_depth(r), 1'b0, 1'b1);
				end
			end
			OP_LEFT, OP_RIGHT: begin
				n = 2 * swap_positions(v) + ((op == OP_LEFT) ? 1 : 2);
				r = swap_positions(n);
				add_node(r, node_depth(r), 1'b0, 1'b1);
			end
			OP_P2N, OP_N2P: begin
				r = swap_positions(v);
				add_node(r, node_depth(r), 1'b0, 1'b1);
			end
			default: begin
				add_node(0, 0, 1'b1, 1'b1);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] want,
			input logic [15:0] got);
		$display("%0t ns: %s expected %0d got %0d", $time, what, want, got);
		mismatches++;
	endtask

	// result check, config tracking and prediction, all on the same edge
	always @(posedge clk) begin
		tree_node_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_nodes.size() == 0) begin
					$display("%0t ns: unexpected beat expected none got idx %0d lvl %0d oot %0d last %0d",
						$time, node_index, node_level, out_of_tree, last);
					mismatches++;
				end else begin
					want = expected_nodes.pop_front();
					if (node_index !== want.idx)
						report_mismatch("node_index", want.idx, node_index);
					if (node_level !== want.lvl)
						report_mismatch("node_level", want.lvl, node_level);
					if (out_of_tree !== want.oot)
						report_mismatch("out_of_tree", want.oot, out_of_tree);
					if (last !== want.last)
						report_mismatch("last", want.last, last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				tree_buckets = 32'(bucket_count);
			end
			if (in_valid && in_ready) begin
				predict_nodes(opcode, node_or_leaf);
			end
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(RX_STREAM, RX_COMB));
			rx_left = $urandom_range(16, 80);
		end
		rx_left--;
		rx_tick++;
		case (rx_mode)
			RX_STREAM: out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(1));
			RX_SPARSE: out_ready <= ($urandom_range(3) == 0);
			default:   out_ready <= ((rx_tick % 7) < 4);
		endcase
	end

	task automatic send_request(input logic [2:0] op, input logic [15:0] v);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(1, 12);
			if ($urandom_range(3) != 0) begin
				gap = $urandom_range(1, 6);
			end
		end
		burst_left--;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		node_or_leaf <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_nodes.size() != 0);
	endtask

	task automatic write_bucket_count(input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		bucket_count <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// full tree after reset: every operation, most of them at their extremes
	task automatic test_default_tree();
		send_request(OP_PATH, 16'd0);
		send_request(OP_PATH, 16'hFFFF);
		send_request(OP_PARENT, 16'd0);
		send_request(OP_PARENT, 16'hFFFF);
		send_request(OP_LEFT, 16'd0);
		send_request(OP_RIGHT, 16'd0);
		send_request(OP_LEFT, 16'h7FFE);
		send_request(OP_RIGHT, 16'hFFFF);
		send_request(OP_P2N, 16'hFFFF);
		send_request(OP_N2P, 16'h1234);
		send_request(OP_P2N, 16'd5);
		send_request(OP_RSVD_A, 16'hFFFF);
		send_request(OP_RSVD_B, 16'd0);
	endtask

	// leaf level only partly populated, operands outside the tree
	task automatic test_partial_level();
		write_bucket_count(16'd10);
		send_request(OP_PATH, 16'd5);
		send_request(OP_PATH, 16'd7);
		send_request(OP_PATH, 16'd12);
		send_request(OP_RIGHT, 16'd4);
		send_request(OP_PARENT, 16'd40);
	endtask

	task automatic test_degenerate_trees();
		write_bucket_count(16'd0);
		send_request(OP_PATH, 16'd3);
		send_request(OP_N2P, 16'd1);
		write_bucket_count(16'd1);
		send_request(OP_PATH, 16'd9);
		send_request(OP_PARENT, 16'd2);
		send_request(OP_N2P, 16'd0);
	endtask

	task automatic test_random_traffic();
		int unsigned p;
		int unsigned k;
		int unsigned l;
		logic [15:0] bc;
		logic [15:0] v;
		logic [2:0]  op;
		for (p = 0; p < 6; p++) begin
			case (p)
				0: bc = 16'd1;
				1: bc = 16'hFFFF;
				2: bc = 16'($urandom_range(2, 255));
				3: bc = 16'h8000;
				4: bc = 16'($urandom_range(256, 65534));
				default: bc = 16'($urandom_range(2, 64));
			endcase
			write_bucket_count(bc);
			for (k = 0; k < 40; k++) begin
				if ($urandom_range(99) < 4)
					op = 3'($urandom_range(OP_RSVD_A, OP_RSVD_B));
				else
					op = 3'($urandom_range(OP_PATH, OP_N2P));
				case ($urandom_range(3))
					0: v = 16'($urandom_range(16'hFFFF));
					1, 2: begin
						l = $urandom_range(0, 15);
						v = 16'(((32'd1 << l) - 1) + ($urandom & ((32'd1 << l) - 1)));
					end
					default: v = 16'($urandom_range(0, tree_buckets));
				endcase
				send_request(op, v);
				if ($urandom_range(29) == 0) begin
					drain();
				end
			end
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_tree();
		test_partial_level();
		test_degenerate_trees();
		test_random_traffic();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("bit_reversed_tree_index_unit_tb OK");
		end else begin
			$display("bit_reversed_tree_index_unit_tb NOT OK");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t ns: timeout", $time);
		$display("bit_reversed_tree_index_unit_tb NOT OK");
		$finish;
	end

endmodule
